[hw/rtl/mrgr_pkg.sv]
package mrgr_pkg;

    // Default sizes of the genotype table.
    localparam int MAX_SAMPLES_DEF = 256;
    localparam int MAX_LOCI_DEF    = 16;
    localparam int CODE_BITS_DEF   = 8;

    // Field widths of the command and result ports.
    localparam int FUNC_W   = 1;
    localparam int SAMPLE_W = 8;
    localparam int LOCUS_W  = 4;
    localparam int ALLELE_W = 8;
    localparam int COUNT_W  = 9;

    // Configuration registers.
    localparam int SCNT_W   = 9;
    localparam int LCNT_W   = 5;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    // Command codes.
    localparam logic [FUNC_W-1:0] FUNC_WRITE = 1'b0;
    localparam logic [FUNC_W-1:0] FUNC_QUERY = 1'b1;

    // Register indexes (word address bit).
    localparam logic REG_SAMPLE_COUNT = 1'b0;
    localparam logic REG_LOCUS_COUNT  = 1'b1;

endpackage

[hw/rtl/masked_row_group_ranker.sv]
// Channel       | Handshake                        | Payload
// --------------+----------------------------------+----------------------------------------
// command in    | start high while busy low        | i_func, i_sample_index, i_locus_index,
//               |                                  | i_allele_code, i_is_missing
// result out    | o_result_valid, one-cycle strobe | o_group_id, o_distinct_count
// register port | psel, penable, pwrite, pready    | paddr, pwdata, prdata
//
// A cell write leaves busy low. A query checks each row in use against the earlier rows
// for an equal key, then, if the queried sample is in use, ranks each first row of a group
// against the queried row; a key comparison reads each locus in use, skipping the masked one,
// then compares it. The result strobe is high in the first cycle with busy low; nothing
// can stall it. Reset is synchronous and active low and leaves the table memory as it is.
module masked_row_group_ranker #(
    parameter int MAX_SAMPLES = mrgr_pkg::MAX_SAMPLES_DEF,
    parameter int MAX_LOCI    = mrgr_pkg::MAX_LOCI_DEF,
    parameter int CODE_BITS   = mrgr_pkg::CODE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Command transaction.
    input  logic                           start,
    output logic                           busy,
    input  logic [mrgr_pkg::FUNC_W-1:0]    i_func,
    input  logic [mrgr_pkg::SAMPLE_W-1:0]  i_sample_index,
    input  logic [mrgr_pkg::LOCUS_W-1:0]   i_locus_index,
    input  logic [mrgr_pkg::ALLELE_W-1:0]  i_allele_code,
    input  logic                           i_is_missing,
    // Result transaction.
    output logic                           o_result_valid,
    output logic [mrgr_pkg::COUNT_W-1:0]   o_group_id,
    output logic [mrgr_pkg::COUNT_W-1:0]   o_distinct_count,
    // Register port.
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mrgr_pkg::PADDR_W-1:0]   paddr,
    input  logic [mrgr_pkg::PDATA_W-1:0]   pwdata,
    output logic [mrgr_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import mrgr_pkg::*;

    localparam int MEM_DEPTH = MAX_SAMPLES * MAX_LOCI;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int NW        = $clog2(MAX_SAMPLES + 1);
    // The locus counter must hold one step past the last locus plus a skipped mask.
    localparam int LCW       = $clog2(MAX_LOCI + 2);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_PICK = 2'd1;
    localparam logic [1:0] S_RD   = 2'd2;
    localparam logic [1:0] S_EV   = 2'd3;

    // Configuration registers.
    logic [SCNT_W-1:0] r_sample_cnt;
    logic [LCNT_W-1:0] r_locus_cnt;
    logic              cfg_wr;

    // Sequencer state.
    logic [1:0]          r_state, n_state;
    logic [NW-1:0]       r_i, n_i;
    logic [NW-1:0]       r_j, n_j;
    logic [NW-1:0]       r_n, n_n;
    logic [NW-1:0]       r_dist, n_dist;
    logic [NW-1:0]       r_small, n_small;
    logic [LCW-1:0]      r_l, n_l;
    logic [LCW-1:0]      r_loci, n_loci;
    logic                r_rank, n_rank;
    logic                r_s_ok, n_s_ok;
    logic [SAMPLE_W-1:0] r_s, n_s;
    logic [LOCUS_W-1:0]  r_m, n_m;
    logic                r_out_vld, n_out_vld;
    logic [COUNT_W-1:0]  r_gid, n_gid;
    logic [COUNT_W-1:0]  r_dc, n_dc;

    // Table memory with one write port and two registered read ports.
    logic [CODE_BITS-1:0] r_mem [MEM_DEPTH];
    logic [CODE_BITS-1:0] r_rd_a, r_rd_b;
    logic [AW-1:0]        rd_addr_a, rd_addr_b, wr_addr;
    logic [CODE_BITS-1:0] wr_data;
    logic                 wr_en;

    logic cmd_accept;
    logic cmp_done, cmp_eq, cmp_lt;

    assign busy       = (r_state != S_IDLE);
    assign cmd_accept = start && !busy;

    // Register port: no wait states, reads are combinational from the registers.
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        if (paddr[2] == REG_LOCUS_COUNT) begin
            prdata = PDATA_W'(r_locus_cnt);
        end else begin
            prdata = PDATA_W'(r_sample_cnt);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_cnt <= SCNT_W'(1);
            r_locus_cnt  <= LCNT_W'(1);
        end else if (cfg_wr) begin
            if (paddr[2] == REG_LOCUS_COUNT) begin
                r_locus_cnt <= pwdata[LCNT_W-1:0];
            end else begin
                r_sample_cnt <= pwdata[SCNT_W-1:0];
            end
        end
    end

    // Cell writes outside the table are dropped; a missing cell is stored as zero.
    always_comb begin
        wr_en   = cmd_accept && (i_func == FUNC_WRITE)
                  && (int'(i_sample_index) < MAX_SAMPLES)
                  && (int'(i_locus_index) < MAX_LOCI);
        wr_addr = AW'(int'(i_sample_index) * MAX_LOCI + int'(i_locus_index));
        wr_data = i_is_missing ? '0 : CODE_BITS'(32'(i_allele_code));
    end

    // Row a is always the candidate row; row b is the earlier row or the queried one.
    always_comb begin
        rd_addr_a = AW'(int'(r_i) * MAX_LOCI + int'(r_l));
        if (r_rank) begin
            rd_addr_b = AW'(int'(r_s) * MAX_LOCI + int'(r_l));
        end else begin
            rd_addr_b = AW'(int'(r_j) * MAX_LOCI + int'(r_l));
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_a <= r_mem[rd_addr_a];
        r_rd_b <= r_mem[rd_addr_b];
    end

    // Sequencer. For each row in use it first looks for an equal key among the earlier
    // rows; a row without one opens a new group, is counted, and, if the queried sample is in
    // use, is then compared with the queried row to count the groups below it.
    always_comb begin
        int sc_i;
        int lc_i;
        int nl_i;
        logic [LCW-1:0] first_l;

        n_state   = r_state;
        n_i       = r_i;
        n_j       = r_j;
        n_n       = r_n;
        n_dist    = r_dist;
        n_small   = r_small;
        n_l       = r_l;
        n_loci    = r_loci;
        n_rank    = r_rank;
        n_s_ok    = r_s_ok;
        n_s       = r_s;
        n_m       = r_m;
        n_out_vld = 1'b0;
        n_gid     = r_gid;
        n_dc      = r_dc;
        cmp_done  = 1'b0;
        cmp_eq    = 1'b0;
        cmp_lt    = 1'b0;

        // Registers out of range act as the nearest legal value.
        sc_i = int'(r_sample_cnt);
        if (sc_i < 1) sc_i = 1;
        if (sc_i > MAX_SAMPLES) sc_i = MAX_SAMPLES;
        lc_i = int'(r_locus_cnt);
        if (lc_i < 1) lc_i = 1;
        if (lc_i > MAX_LOCI) lc_i = MAX_LOCI;

        // Next locus of the key, stepping over the masked one.
        nl_i = int'(r_l) + 1;
        if (nl_i == int'(r_m)) nl_i = int'(r_l) + 2;
        first_l = (r_m == '0) ? LCW'(1) : '0;

        case (r_state)
            S_IDLE: begin
                if (cmd_accept && (i_func == FUNC_QUERY)) begin
                    n_s     = i_sample_index;
                    n_m     = i_locus_index;
                    n_n     = NW'(sc_i);
                    n_loci  = LCW'(lc_i);
                    n_s_ok  = (int'(i_sample_index) < sc_i);
                    n_i     = '0;
                    n_j     = '0;
                    n_dist  = '0;
                    n_small = '0;
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (r_i == r_n) begin
                    n_out_vld = 1'b1;
                    n_gid     = r_s_ok ? COUNT_W'(32'(r_small) + 32'd1) : '0;
                    n_dc      = COUNT_W'(32'(r_dist));
                    n_state   = S_IDLE;
                end else if (r_j < r_i) begin
                    n_rank  = 1'b0;
                    n_l     = first_l;
                    n_state = S_RD;
                end else begin
                    n_dist = r_dist + 1'b1;
                    if (r_s_ok) begin
                        n_rank  = 1'b1;
                        n_l     = first_l;
                        n_state = S_RD;
                    end else begin
                        n_i = r_i + 1'b1;
                        n_j = '0;
                    end
                end
            end
            S_RD: begin
                // Past the last locus in use: the keys are equal.
                if (r_l >= r_loci) begin
                    cmp_done = 1'b1;
                    cmp_eq   = 1'b1;
                end else begin
                    n_state = S_EV;
                end
            end
            S_EV: begin
                if (r_rd_a != r_rd_b) begin
                    cmp_done = 1'b1;
                    cmp_lt   = (r_rd_a < r_rd_b);
                end else begin
                    n_l     = LCW'(nl_i);
                    n_state = S_RD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (cmp_done) begin
            n_state = S_PICK;
            if (!r_rank) begin
                if (cmp_eq) begin
                    n_i = r_i + 1'b1;
                    n_j = '0;
                end else begin
                    n_j = r_j + 1'b1;
                end
            end else begin
                if (cmp_lt) begin
                    n_small = r_small + 1'b1;
                end
                n_i = r_i + 1'b1;
                n_j = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            r_rank    <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
            r_n       <= '0;
            r_dist    <= '0;
            r_small   <= '0;
            r_l       <= '0;
            r_loci    <= '0;
            r_s_ok    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            r_rank    <= n_rank;
            r_i       <= n_i;
            r_j       <= n_j;
            r_n       <= n_n;
            r_dist    <= n_dist;
            r_small   <= n_small;
            r_l       <= n_l;
            r_loci    <= n_loci;
            r_s_ok    <= n_s_ok;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_s   <= n_s;
        r_m   <= n_m;
        r_gid <= n_gid;
        r_dc  <= n_dc;
    end

    assign o_result_valid   = r_out_vld;
    assign o_group_id       = r_gid;
    assign o_distinct_count = r_dc;

endmodule

[hw/rtl/mrgr_checker.sv]
module mrgr_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [mrgr_pkg::FUNC_W-1:0]    i_func,
    input  logic                           o_result_valid,
    input  logic [mrgr_pkg::COUNT_W-1:0]   o_distinct_count,
    input  logic                           pready
);
    import mrgr_pkg::*;

    // A query keeps the block busy until its result, so results never come back to back.
    a_no_back_to_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("two results in consecutive cycles");

    // Every result closes a busy period.
    a_result_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without a preceding query");

    // A query holds the command side; a cell write does not.
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == FUNC_QUERY)) |=> busy)
        else $error("query accepted without going busy");

    a_write_not_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_func == FUNC_WRITE)) |=> !busy)
        else $error("cell write made the block busy");

    // At least one row is always in use, so there is at least one group.
    a_groups_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> (o_distinct_count != '0) && pready)
        else $error("result reports no groups");

endmodule

bind masked_row_group_ranker mrgr_checker u_mrgr_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .start            (start),
    .busy             (busy),
    .i_func           (i_func),
    .o_result_valid   (o_result_valid),
    .o_distinct_count (o_distinct_count),
    .pready           (pready)
);

[sim/group_rank_check_pkg.sv]
`timescale 1ns / 100ps
package group_rank_check_pkg;
    import mrgr_pkg::*;

    // One command transaction as the driver presents it.
    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [SAMPLE_W-1:0] sample;
        logic [LOCUS_W-1:0]  locus;
        logic [ALLELE_W-1:0] allele;
        logic                missing;
    } command_t;

    // One result transaction.
    typedef struct packed {
        logic [COUNT_W-1:0] group_id;
        logic [COUNT_W-1:0] distinct_count;
    } rank_t;

    class group_rank_scoreboard;
        logic [CODE_BITS_DEF-1:0] genotypes [MAX_SAMPLES_DEF][MAX_LOCI_DEF];
        logic [SCNT_W-1:0]        sample_reg;
        logic [LCNT_W-1:0]        locus_reg;
        rank_t                    pending_ranks [$];
        int                       mismatches;
        int                       results_checked;
        int                       writes_seen;
        int                       queries_seen;

        function new();
            sample_reg      = SCNT_W'(1);
            locus_reg       = LCNT_W'(1);
            mismatches      = 0;
            results_checked = 0;
            writes_seen     = 0;
            queries_seen    = 0;
            foreach (genotypes[s, l]) genotypes[s][l] = '0;
        endfunction

        function void set_register(logic reg_index, logic [PDATA_W-1:0] value);
            if (reg_index == REG_SAMPLE_COUNT) begin
                sample_reg = value[SCNT_W-1:0];
            end else begin
                locus_reg = value[LCNT_W-1:0];
            end
        endfunction

        // Register values of zero act as one, values above the table size act as the size.
        function int rows_in_use();
            if (sample_reg == 0) return 1;
            if (sample_reg > MAX_SAMPLES_DEF) return MAX_SAMPLES_DEF;
            return int'(sample_reg);
        endfunction

        function int loci_in_use();
            if (locus_reg == 0) return 1;
            if (locus_reg > MAX_LOCI_DEF) return MAX_LOCI_DEF;
            return int'(locus_reg);
        endfunction

        function int compare_keys(int a, int b, int masked, int loci);
            for (int l = 0; l < loci; l++) begin
                if (l != masked) begin
                    if (genotypes[a][l] < genotypes[b][l]) return -1;
                    if (genotypes[a][l] > genotypes[b][l]) return 1;
                end
            end
            return 0;
        endfunction

        // A row counts toward the distinct keys only if no earlier row has the same key.
        function rank_t predict_rank(int s, int masked);
            rank_t r;
            int    n;
            int    loci;
            int    distinct;
            int    smaller;
            bit    first;
            n        = rows_in_use();
            loci     = loci_in_use();
            distinct = 0;
            smaller  = 0;
            for (int i = 0; i < n; i++) begin
                first = 1'b1;
                for (int j = 0; j < i && first; j++) begin
                    if (compare_keys(i, j, masked, loci) == 0) first = 1'b0;
                end
                if (first) begin
                    distinct++;
                    if (s < n && compare_keys(i, s, masked, loci) < 0) smaller++;
                end
            end
            r.group_id       = (s < n) ? COUNT_W'(smaller + 1) : '0;
            r.distinct_count = COUNT_W'(distinct);
            return r;
        endfunction

        function void note_command(command_t cmd);
            if (cmd.func == FUNC_WRITE) begin
                genotypes[cmd.sample][cmd.locus] =
                    cmd.missing ? '0 : cmd.allele[CODE_BITS_DEF-1:0];
                writes_seen++;
            end else begin
                pending_ranks.push_back(predict_rank(int'(cmd.sample), int'(cmd.locus)));
                queries_seen++;
            end
        endfunction

        function void check_result(logic [COUNT_W-1:0] group_id,
                                   logic [COUNT_W-1:0] distinct_count);
            rank_t want;
            if (pending_ranks.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no query waiting: group_id %0d distinct_count %0d",
                             $realtime, group_id, distinct_count);
                return;
            end
            want = pending_ranks.pop_front();
            results_checked++;
            if (group_id !== want.group_id || distinct_count !== want.distinct_count) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: group_id exp %0d got %0d, distinct_count exp %0d got %0d",
                             $realtime, want.group_id, group_id,
                             want.distinct_count, distinct_count);
            end
        endfunction

        function int pending();
            return pending_ranks.size();
        endfunction
    endclass

endpackage

[sim/masked_row_group_ranker_tb.sv]
`timescale 1ns / 100ps
module masked_row_group_ranker_tb;
    import mrgr_pkg::*;
    import group_rank_check_pkg::*;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 start;
    logic                 busy;
    logic [FUNC_W-1:0]    i_func;
    logic [SAMPLE_W-1:0]  i_sample_index;
    logic [LOCUS_W-1:0]   i_locus_index;
    logic [ALLELE_W-1:0]  i_allele_code;
    logic                 i_is_missing;
    logic                 o_result_valid;
    logic [COUNT_W-1:0]   o_group_id;
    logic [COUNT_W-1:0]   o_distinct_count;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    group_rank_scoreboard sb;

    // Cells written so far. A query reads every cell of the rows and loci in use, and
    // the table holds garbage until a cell is written, so each phase first fills its
    // region before any query goes out.
    bit cell_written [MAX_SAMPLES_DEF][MAX_LOCI_DEF];

    // When set, the sender presents commands back to back for the whole phase.
    bit burst;
    int settings_run;

    masked_row_group_ranker dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_sample_index   (i_sample_index),
        .i_locus_index    (i_locus_index),
        .i_allele_code    (i_allele_code),
        .i_is_missing     (i_is_missing),
        .o_result_valid   (o_result_valid),
        .o_group_id       (o_group_id),
        .o_distinct_count (o_distinct_count),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Results are a one-cycle strobe that cannot be held off, so every rising edge with
    // the strobe high is a result transaction.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_result_valid === 1'b1)
            sb.check_result(o_group_id, o_distinct_count);
    end

    function automatic int gap_draw();
        return burst ? 0 : $urandom_range(0, 14);
    endfunction

    // Mostly a tiny alphabet so that masked keys collide often, with the code extremes
    // and fully random codes mixed in.
    function automatic int allele_draw();
        case ($urandom_range(0, 9))
            0: return 8'hFF;
            1: return 8'h00;
            2: return $urandom_range(0, 255);
            default: return $urandom_range(0, 2);
        endcase
    endfunction

    // An index inside the region in use, or now and then anywhere in the field's range.
    function automatic int pick_index(int in_use, int full, int pct_outside);
        if ($urandom_range(0, 99) < pct_outside) return $urandom_range(0, full - 1);
        return $urandom_range(0, in_use - 1);
    endfunction

    // Drives one command transaction. Entered and left just after a falling edge; start
    // stays high on exit so that a following command with no gap goes out back to back.
    task automatic send_cmd(input logic [FUNC_W-1:0] func, input int s, input int l,
                            input int allele, input bit missing);
        int       gap;
        command_t cmd;
        gap         = gap_draw();
        cmd.func    = func;
        cmd.sample  = SAMPLE_W'(s);
        cmd.locus   = LOCUS_W'(l);
        cmd.allele  = ALLELE_W'(allele);
        cmd.missing = missing;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start          <= 1'b1;
        i_func         <= cmd.func;
        i_sample_index <= cmd.sample;
        i_locus_index  <= cmd.locus;
        i_allele_code  <= cmd.allele;
        i_is_missing   <= cmd.missing;
        // The command is taken at the first rising edge that sees busy low.
        do @(posedge i_clk); while (busy !== 1'b0);
        sb.note_command(cmd);
        if (func == FUNC_WRITE) cell_written[s][l] = 1'b1;
        @(negedge i_clk);
    endtask

    // Register write: a setup cycle, then an access cycle that completes on pready.
    task automatic write_reg(input logic reg_index, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_index, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        sb.set_register(reg_index, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Brings the block to idle: no command pending and every query answered, then a
    // settling wait before returning.
    task automatic settle();
        start <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Writes every cell of the region in use that has never been written.
    task automatic fill_in_use();
        int n;
        int loci;
        n    = sb.rows_in_use();
        loci = sb.loci_in_use();
        for (int s = 0; s < n; s++) begin
            for (int l = 0; l < loci; l++) begin
                if (!cell_written[s][l])
                    send_cmd(FUNC_WRITE, s, l, allele_draw(), $urandom_range(0, 7) == 0);
            end
        end
    endtask

    // One register setting: program it while idle, fill the region it uses, then a
    // random mix of cell writes and queries. A small share of the writes lands outside
    // the region in use, and a small share of the queries names a sample or masked
    // locus that is not in use.
    task automatic run_phase(input int scnt, input int lcnt, input int items,
                             input int query_pct);
        int n;
        int loci;
        settle();
        write_reg(REG_SAMPLE_COUNT, scnt);
        write_reg(REG_LOCUS_COUNT, lcnt);
        settings_run++;
        n     = sb.rows_in_use();
        loci  = sb.loci_in_use();
        burst = ($urandom_range(0, 3) == 0);
        fill_in_use();
        for (int k = 0; k < items; k++) begin
            if ($urandom_range(0, 99) < query_pct) begin
                send_cmd(FUNC_QUERY, pick_index(n, MAX_SAMPLES_DEF, 20),
                         pick_index(loci, MAX_LOCI_DEF, 20),
                         $urandom_range(0, 255), $urandom_range(0, 1) == 1);
            end else begin
                send_cmd(FUNC_WRITE, pick_index(n, MAX_SAMPLES_DEF, 15),
                         pick_index(loci, MAX_LOCI_DEF, 15),
                         allele_draw(), $urandom_range(0, 7) == 0);
            end
        end
    endtask

    initial begin
        sb             = new();
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_func         = FUNC_WRITE;
        i_sample_index = '0;
        i_locus_index  = '0;
        i_allele_code  = '0;
        i_is_missing   = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        burst          = 1'b0;
        settings_run   = 1;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset setting of one sample and one locus. Masking the only locus leaves an
        // empty key; a sample out of use answers group 0, and a masked locus out of use
        // keeps the whole row.
        send_cmd(FUNC_WRITE, 0, 0, 8'hFF, 1'b0);
        send_cmd(FUNC_QUERY, 0, 0, 8'h00, 1'b0);
        send_cmd(FUNC_QUERY, 255, 15, 8'hFF, 1'b1);
        settle();

        // Four samples by three loci, built so that masking locus 1 merges rows 0 to 2.
        // Row 2 writes code 0xFF as missing, which must store as 0.
        write_reg(REG_SAMPLE_COUNT, 4);
        write_reg(REG_LOCUS_COUNT, 3);
        settings_run++;
        for (int s = 0; s < 4; s++) begin
            for (int l = 0; l < 3; l++) begin
                send_cmd(FUNC_WRITE, s, l,
                         (l == 0 && s >= 2) ? 8'hFF : (l == 1 && s[0]) ? 8'd5 : 8'd0,
                         s == 2 && l == 0);
            end
        end
        // Writes outside the rows and loci in use are still stored.
        send_cmd(FUNC_WRITE, 255, 15, 8'h00, 1'b0);
        send_cmd(FUNC_WRITE, 170, 10, 8'hAA, 1'b1);
        send_cmd(FUNC_QUERY, 0, 0, 8'h00, 1'b0);
        send_cmd(FUNC_QUERY, 1, 1, 8'h00, 1'b0);
        send_cmd(FUNC_QUERY, 3, 2, 8'h00, 1'b0);
        send_cmd(FUNC_QUERY, 2, 15, 8'h00, 1'b0);
        send_cmd(FUNC_QUERY, 200, 1, 8'h00, 1'b0);

        // Random phases on small tables, so that filling each region keeps the run near
        // a hundred commands. Register values of zero and a locus count above the table
        // width are covered as well.
        run_phase(8, 4, 20, 40);
        run_phase(0, 0, 6, 50);
        run_phase(2, 31, 8, 50);
        run_phase(5, 2, 8, 50);

        settle();
        repeat (20) @(negedge i_clk);
        $display("Covered %0d cell writes and %0d queries over %0d register settings.",
                 sb.writes_seen, sb.queries_seen, settings_run);
        $display("Compared %0d query results; %0d disagreed.",
                 sb.results_checked, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #50_000_000;
        $display("Mismatches found");
        $finish;
    end

endmodule
